>>> design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB        = 2'd0,
    CMD_ABSORB_FINISH = 2'd1,
    CMD_FINISH        = 2'd2
  } cmd_code_e;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned NumHash   = 5;
  localparam int unsigned IdxW      = 3;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] HashInit [NumHash] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic              push;
    byte_sel_e         byte_sel;
    logic              latch_len;
    logic              len_plus8;
    logic              round;
    logic [RoundW-1:0] round_idx;
    logic              add;
    logic              reinit;
    logic [IdxW-1:0]   out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } dp_status_t;

endpackage

>>> design/sha1_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Byte packing, 16-word schedule window, round registers and chaining words.
// ----------------------------------------------------------------------------
module sha1_dp import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  output dp_status_t  status_o,
  output logic [31:0] digest_word_o
);

  logic [31:0] h_q [NumHash];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [23:0] part_q;
  logic [63:0] bit_count_q;
  logic [63:0] len_q;

  logic [5:0]  pos;
  logic [7:0]  byte_val;
  logic [63:0] len_sh;
  logic [5:0]  len_amt;
  logic [31:0] new_word;
  logic [31:0] f_val, k_val, t_val, w_next, x_val;

  assign pos      = bit_count_q[8:3];
  assign status_o.pos = pos;
  assign len_amt  = {~pos[2:0], 3'b000};
  assign len_sh   = len_q >> len_amt;
  assign new_word = {part_q, byte_val};
  assign digest_word_o = h_q[cmd_i.out_idx];

  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_DATA: byte_val = data_byte_i;
      BYTE_PAD:  byte_val = PadByte;
      BYTE_LEN:  byte_val = len_sh[7:0];
      default:   byte_val = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd_i.round_idx < RoundW'(20)) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (cmd_i.round_idx < RoundW'(40)) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (cmd_i.round_idx < RoundW'(60)) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
    t_val  = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];
    x_val  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_next = {x_val[30:0], x_val[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= '0;
      for (int i = 0; i < NumHash; i++) begin
        h_q[i] <= HashInit[i];
      end
    end else begin
      if (cmd_i.reinit) begin
        bit_count_q <= '0;
        for (int i = 0; i < NumHash; i++) begin
          h_q[i] <= HashInit[i];
        end
      end else begin
        if (cmd_i.push) begin
          bit_count_q <= bit_count_q + 64'd8;
        end
        if (cmd_i.add) begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_len) begin
      len_q <= cmd_i.len_plus8 ? bit_count_q + 64'd8 : bit_count_q;
    end
    if (cmd_i.push) begin
      part_q <= new_word[23:0];
      a_q    <= h_q[0];
      b_q    <= h_q[1];
      c_q    <= h_q[2];
      d_q    <= h_q[3];
      e_q    <= h_q[4];
      if (pos[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= new_word;
      end
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_next;
    end
  end

endmodule

>>> design/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, compression rounds and digest readout.
// ----------------------------------------------------------------------------
module sha1_ctrl import sha1_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdxW-1:0] word_index_o,
  output logic            last_word_o,
  input  dp_status_t      status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);
  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(NumHash - 1);

  state_e            state_q;
  logic [RoundW-1:0] round_q;
  logic [IdxW-1:0]   idx_q;
  logic              fin_q, first_q, lenph_q, done_q;
  logic              block_end;

  assign block_end    = (status_i.pos == 6'd63);
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == LastIdx);

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = BYTE_DATA;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_ABSORB: cmd_o.push = 1'b1;
            CMD_ABSORB_FINISH: begin
              cmd_o.push      = 1'b1;
              cmd_o.latch_len = 1'b1;
              cmd_o.len_plus8 = 1'b1;
            end
            CMD_FINISH: cmd_o.latch_len = 1'b1;
            default: ;
          endcase
        end
      end
      ST_COMP: cmd_o.round = 1'b1;
      ST_ADD:  cmd_o.add = 1'b1;
      ST_PAD: begin
        cmd_o.push = 1'b1;
        if (first_q) begin
          cmd_o.byte_sel = BYTE_PAD;
        end else if (lenph_q || status_i.pos == 6'd56) begin
          cmd_o.byte_sel = BYTE_LEN;
        end else begin
          cmd_o.byte_sel = BYTE_ZERO;
        end
      end
      ST_OUT:  cmd_o.reinit = out_ready_i && (idx_q == LastIdx);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            case (command_i)
              CMD_ABSORB: begin
                fin_q <= 1'b0;
                if (block_end) state_q <= ST_COMP;
              end
              CMD_ABSORB_FINISH: begin
                fin_q   <= 1'b1;
                first_q <= 1'b1;
                lenph_q <= 1'b0;
                done_q  <= 1'b0;
                state_q <= block_end ? ST_COMP : ST_PAD;
              end
              CMD_FINISH: begin
                fin_q   <= 1'b1;
                first_q <= 1'b1;
                lenph_q <= 1'b0;
                done_q  <= 1'b0;
                state_q <= ST_PAD;
              end
              default: ;
            endcase
          end
        end
        ST_COMP: begin
          if (round_q == LastRound) begin
            round_q <= '0;
            state_q <= ST_ADD;
          end else begin
            round_q <= round_q + 1'b1;
          end
        end
        ST_ADD: begin
          idx_q <= '0;
          if (!fin_q) begin
            state_q <= ST_IDLE;
          end else if (done_q) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_PAD;
          end
        end
        ST_PAD: begin
          first_q <= 1'b0;
          if (!first_q && status_i.pos == 6'd56) lenph_q <= 1'b1;
          if (block_end) begin
            done_q  <= lenph_q;
            state_q <= ST_COMP;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (idx_q == LastIdx) begin
              idx_q   <= '0;
              fin_q   <= 1'b0;
              done_q  <= 1'b0;
              lenph_q <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/sha1_hash_engine.sv
// An absorb transfer takes one byte; a byte that fills the 64-byte block starts
// 80 rounds, one round per cycle, then the chaining add, and no new byte is
// accepted until they are done. A finish pads one byte per cycle, compresses
// each padded block the same way, then offers five digest transfers.
// Reset loads the SHA-1 initial chaining words and clears the bit count.
// ----------------------------------------------------------------------------
// SHA-1 hash engine top level
// Streaming SHA-1 with byte input, hardware padding and word-wise digest out.
// ----------------------------------------------------------------------------
module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha1_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .status_o      (status),
    .digest_word_o (digest_word_o)
  );

endmodule
